FILE: rtl/core/uer_pkg.sv
package uer_pkg;

  localparam int NUM_SENSORS = 4;
  localparam int SLOT_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

  localparam logic [15:0] MEASURE_PERIOD_RST = 16'd60;
  localparam logic [15:0] ECHO_TIMEOUT_RST   = 16'd30;
  localparam logic [15:0] TRIGGER_PULSE_RST  = 16'd10;
  localparam logic        TIMER_READY_RST    = 1'b1;

  // Reciprocal of 29 scaled by 2^24, rounded up; exact for 19-bit dividends.
  localparam logic [19:0] RECIP29 = 20'd578525;
  localparam int          RECIP_SHIFT = 24;
  localparam logic [19:0] ROUND_BIAS = 20'd29;

  typedef enum logic [1:0] {
    CMD_POLL     = 2'd0,
    CMD_CAPTURE  = 2'd1,
    CMD_TRIG_END = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MEASURE_PERIOD = 2'd0,
    REG_ECHO_TIMEOUT   = 2'd1,
    REG_TRIGGER_PULSE  = 2'd2,
    REG_TIMER_READY    = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_WAIT_RISE = 5'b00010,
    PH_WAIT_FALL = 5'b00100,
    PH_READY     = 5'b01000,
    PH_ERROR     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_ms;
    logic        monitor_enable;
    logic [1:0]  capture_channel;
    logic [15:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic        result_ready;
    logic [1:0]  result_sensor;
    logic [13:0] distance_mm;
    logic        result_valid;
    logic        started;
    logic [1:0]  started_sensor;
    logic        trigger_level;
  } out_item_t;

  typedef struct packed {
    logic [15:0] measure_period_ms;
    logic [15:0] echo_timeout_ms;
    logic [15:0] trigger_pulse_us;
    logic        timer_ready;
  } cfg_t;

  // Sensor index as carried in the 2-bit result fields.
  function automatic logic [1:0] sensor_field(input logic [SLOT_W-1:0] slot);
    logic [SLOT_W+1:0] wide;
    wide = {2'b00, slot};
    return wide[1:0];
  endfunction

  // Rounded width to millimeters: (w*10 + 29) / 58, done as a halving
  // followed by a multiply with the reciprocal of 29.
  function automatic logic [13:0] width_to_mm(input logic [15:0] w);
    logic [19:0] x;
    logic [18:0] y;
    logic [38:0] p;
    logic [14:0] q;
    x = {1'b0, w, 3'b000} + {3'b000, w, 1'b0} + ROUND_BIAS;
    y = x[19:1];
    p = y * RECIP29;
    q = p[38:RECIP_SHIFT];
    return q[13:0];
  endfunction

endpackage

FILE: rtl/core/uer_cfg_regs.sv
module uer_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  output uer_pkg::cfg_t       cfg
);

  uer_pkg::cfg_t cfg_r;
  uer_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (uer_pkg::reg_idx_t'(cfg_index))
        uer_pkg::REG_MEASURE_PERIOD: cfg_nxt.measure_period_ms = cfg_data;
        uer_pkg::REG_ECHO_TIMEOUT:   cfg_nxt.echo_timeout_ms = cfg_data;
        uer_pkg::REG_TRIGGER_PULSE:  cfg_nxt.trigger_pulse_us = cfg_data;
        uer_pkg::REG_TIMER_READY:    cfg_nxt.timer_ready = cfg_data[0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.measure_period_ms <= uer_pkg::MEASURE_PERIOD_RST;
      cfg_r.echo_timeout_ms   <= uer_pkg::ECHO_TIMEOUT_RST;
      cfg_r.trigger_pulse_us  <= uer_pkg::TRIGGER_PULSE_RST;
      cfg_r.timer_ready       <= uer_pkg::TIMER_READY_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: rtl/core/uer_range_core.sv
module uer_range_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  uer_pkg::in_item_t    item,
  input  uer_pkg::cfg_t        cfg,
  output uer_pkg::out_item_t   result
);

  uer_pkg::phase_t             phase_r, phase_nxt;
  logic [uer_pkg::SLOT_W-1:0]  active_r, active_nxt;
  logic [uer_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [31:0]                 start_r, start_nxt;
  logic [31:0]                 last_launch_r, last_launch_nxt;
  logic                        due_now_r, due_now_nxt;
  logic [15:0]                 rising_r, rising_nxt;
  logic [15:0]                 width_r, width_nxt;
  logic                        trig_r, trig_nxt;

  logic [31:0] since_start;
  logic [31:0] since_launch;
  logic        timed_out;
  logic        period_done;
  logic        on_channel;
  logic [15:0] plain_width;
  logic [13:0] mm;

  assign since_start  = item.now_ms - start_r;
  assign since_launch = item.now_ms - last_launch_r;
  assign timed_out    = since_start >= {16'd0, cfg.echo_timeout_ms};
  assign period_done  = since_launch >= {16'd0, cfg.measure_period_ms};
  assign on_channel   = item.capture_channel == uer_pkg::sensor_field(active_r);
  assign plain_width  = item.capture_value - rising_r;
  assign mm           = uer_pkg::width_to_mm(width_r);

  always_comb begin
    phase_nxt       = phase_r;
    active_nxt      = active_r;
    slot_nxt        = slot_r;
    start_nxt       = start_r;
    last_launch_nxt = last_launch_r;
    due_now_nxt     = due_now_r;
    rising_nxt      = rising_r;
    width_nxt       = width_r;
    trig_nxt        = trig_r;
    result          = '0;

    unique case (uer_pkg::cmd_t'(item.command))
      uer_pkg::CMD_POLL: begin
        if (!item.monitor_enable) begin
          if (phase_r != uer_pkg::PH_IDLE) begin
            trig_nxt  = 1'b0;
            phase_nxt = uer_pkg::PH_IDLE;
          end
          last_launch_nxt = item.now_ms;
          due_now_nxt     = 1'b0;
        end else begin
          if ((phase_r == uer_pkg::PH_WAIT_RISE || phase_r == uer_pkg::PH_WAIT_FALL) &&
              timed_out) begin
            trig_nxt  = 1'b0;
            phase_nxt = uer_pkg::PH_ERROR;
          end
          if (phase_nxt == uer_pkg::PH_READY || phase_nxt == uer_pkg::PH_ERROR) begin
            result.result_ready  = 1'b1;
            result.result_sensor = uer_pkg::sensor_field(active_r);
            if (phase_nxt == uer_pkg::PH_READY) begin
              result.distance_mm  = mm;
              result.result_valid = 1'b1;
            end
            phase_nxt = uer_pkg::PH_IDLE;
            if (slot_r == uer_pkg::SLOT_W'(uer_pkg::NUM_SENSORS - 1)) begin
              slot_nxt = '0;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
          end
          // The launch sees the slot already advanced by a hand-back above.
          if (cfg.timer_ready && phase_nxt == uer_pkg::PH_IDLE &&
              (due_now_r || period_done)) begin
            last_launch_nxt       = item.now_ms;
            due_now_nxt           = 1'b0;
            active_nxt            = slot_nxt;
            start_nxt             = item.now_ms;
            rising_nxt            = '0;
            width_nxt             = '0;
            phase_nxt             = uer_pkg::PH_WAIT_RISE;
            trig_nxt              = 1'b1;
            result.started        = 1'b1;
            result.started_sensor = uer_pkg::sensor_field(slot_nxt);
          end
        end
      end
      uer_pkg::CMD_CAPTURE: begin
        if (on_channel) begin
          if (phase_r == uer_pkg::PH_WAIT_RISE) begin
            rising_nxt = item.capture_value;
            phase_nxt  = uer_pkg::PH_WAIT_FALL;
          end else if (phase_r == uer_pkg::PH_WAIT_FALL) begin
            // On wrap with the trigger high the timer reloads at the pulse
            // length, which modulo 2^16 is just that register added in.
            if (item.capture_value < rising_r && trig_r) begin
              width_nxt = plain_width + cfg.trigger_pulse_us;
            end else begin
              width_nxt = plain_width;
            end
            phase_nxt = uer_pkg::PH_READY;
          end
        end
      end
      uer_pkg::CMD_TRIG_END: begin
        trig_nxt = 1'b0;
      end
      default: begin
        trig_nxt = trig_r;
      end
    endcase

    result.trigger_level = trig_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= uer_pkg::PH_IDLE;
      active_r      <= '0;
      slot_r        <= '0;
      start_r       <= '0;
      last_launch_r <= '0;
      due_now_r     <= 1'b1;
      rising_r      <= '0;
      width_r       <= '0;
      trig_r        <= 1'b0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      active_r      <= active_nxt;
      slot_r        <= slot_nxt;
      start_r       <= start_nxt;
      last_launch_r <= last_launch_nxt;
      due_now_r     <= due_now_nxt;
      rising_r      <= rising_nxt;
      width_r       <= width_nxt;
      trig_r        <= trig_nxt;
    end
  end

endmodule

FILE: rtl/core/ultrasonic_echo_ranging_scheduler.sv
// A beat accepted into the input register passes into the output register,
// out_data, as soon as that is free. Throughput: one beat per cycle while
// out_data is not stalled; while a finished result waits in the output
// register the input register takes one more beat, and then both are full.
// Reset (rst_n, synchronous, active low) empties both registers, returns the
// ranging state to idle with the first launch due at once, and loads the
// configuration registers with their default values.
module ultrasonic_echo_ranging_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  uer_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output uer_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data
);

  uer_pkg::cfg_t      cfg;
  uer_pkg::in_item_t  item_r;
  logic               item_valid_r;
  uer_pkg::out_item_t result;
  uer_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  logic               out_free;
  logic               step;

  assign out_free  = !out_valid_r || out_ready;
  assign step      = item_valid_r && out_free;
  assign in_ready  = !item_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  uer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  uer_range_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

endmodule

FILE: tb/ultrasonic_echo_ranging_scheduler_tb.sv
`timescale 1ns / 1ps

module ultrasonic_echo_ranging_scheduler_tb;
  import uer_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Ranging state as the block should hold it.
  phase_t      rng_phase;
  logic [1:0]  rng_active;
  logic [1:0]  rng_slot;
  logic [31:0] rng_start_ms;
  logic [31:0] rng_last_launch_ms;
  logic        rng_launch_now;
  logic [15:0] rng_rise_stamp;
  logic [15:0] rng_echo_width;
  logic        rng_trig_high;

  logic [15:0] period_ms;
  logic [15:0] timeout_ms;
  logic [15:0] pulse_us;
  logic        timer_ok;

  out_item_t   pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic [31:0] clock_ms;
  int unsigned step_hi;

  ultrasonic_echo_ranging_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic void reset_ranging();
    rng_phase = PH_IDLE;
    rng_active = '0;
    rng_slot = '0;
    rng_start_ms = '0;
    rng_last_launch_ms = '0;
    rng_launch_now = 1'b1;
    rng_rise_stamp = '0;
    rng_echo_width = '0;
    rng_trig_high = 1'b0;
    period_ms = 16'd60;
    timeout_ms = 16'd30;
    pulse_us = 16'd10;
    timer_ok = 1'b1;
  endfunction

  function automatic out_item_t ranging_step(input in_item_t it);
    out_item_t   r;
    logic [31:0] elapsed;
    int unsigned wrap_len;
    int unsigned mm;
    r = '0;
    case (it.command)
      CMD_POLL: begin
        if (!it.monitor_enable) begin
          if (rng_phase != PH_IDLE) begin
            rng_trig_high = 1'b0;
            rng_phase = PH_IDLE;
          end
          rng_last_launch_ms = it.now_ms;
          rng_launch_now = 1'b0;
        end else begin
          elapsed = it.now_ms - rng_start_ms;
          if ((rng_phase == PH_WAIT_RISE || rng_phase == PH_WAIT_FALL) &&
              elapsed >= 32'(timeout_ms)) begin
            rng_trig_high = 1'b0;
            rng_phase = PH_ERROR;
          end
          if (rng_phase == PH_READY || rng_phase == PH_ERROR) begin
            r.result_ready = 1'b1;
            r.result_sensor = rng_active;
            if (rng_phase == PH_READY) begin
              mm = (32'(rng_echo_width) * 10 + 29) / 58;
              r.distance_mm = 14'(mm);
              r.result_valid = 1'b1;
            end
            rng_phase = PH_IDLE;
            rng_slot = 2'((rng_slot + 1) % NUM_SENSORS);
          end
          elapsed = it.now_ms - rng_last_launch_ms;
          if (timer_ok && rng_phase == PH_IDLE &&
              (rng_launch_now || elapsed >= 32'(period_ms))) begin
            rng_last_launch_ms = it.now_ms;
            rng_launch_now = 1'b0;
            rng_active = rng_slot;
            rng_start_ms = it.now_ms;
            rng_rise_stamp = '0;
            rng_echo_width = '0;
            rng_phase = PH_WAIT_RISE;
            rng_trig_high = 1'b1;
            r.started = 1'b1;
            r.started_sensor = rng_active;
          end
        end
      end
      CMD_CAPTURE: begin
        if (it.capture_channel == rng_active) begin
          if (rng_phase == PH_WAIT_RISE) begin
            rng_rise_stamp = it.capture_value;
            rng_phase = PH_WAIT_FALL;
          end else if (rng_phase == PH_WAIT_FALL) begin
            if (it.capture_value >= rng_rise_stamp) begin
              rng_echo_width = it.capture_value - rng_rise_stamp;
            end else begin
              // The capture timer wraps at the trigger pulse length while the
              // trigger is high, and at the full 16-bit range otherwise.
              wrap_len = rng_trig_high ? ((32'(pulse_us) - 1) & 32'hFFFF) + 1 : 65536;
              rng_echo_width = 16'(wrap_len - 32'(rng_rise_stamp) + 32'(it.capture_value));
            end
            rng_phase = PH_READY;
          end
        end
      end
      CMD_TRIG_END: rng_trig_high = 1'b0;
      default: ;
    endcase
    r.trigger_level = rng_trig_high;
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [1:0] cmd, input logic [31:0] now,
                                         input logic en, input logic [1:0] chan,
                                         input logic [15:0] val, input bit typed,
                                         input out_item_t want);
    stim_row_t row;
    row.item.command = cmd;
    row.item.now_ms = now;
    row.item.monitor_enable = en;
    row.item.capture_channel = chan;
    row.item.capture_value = val;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  function automatic in_item_t random_ranging_item();
    in_item_t    it;
    int unsigned pick;
    it.command = CMD_POLL;
    it.now_ms = $urandom;
    it.monitor_enable = 1'($urandom_range(0, 1));
    it.capture_channel = 2'($urandom_range(0, 3));
    it.capture_value = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      clock_ms = clock_ms + $urandom_range(0, step_hi);
      it.now_ms = clock_ms;
      it.monitor_enable = ($urandom_range(0, 99) >= 8);
    end else if (pick < 50) begin
      it.command = CMD_POLL;
    end else if (pick < 75) begin
      it.command = CMD_CAPTURE;
      it.capture_channel = rng_active;
    end else if (pick < 85) begin
      it.command = CMD_CAPTURE;
    end else if (pick < 95) begin
      it.command = CMD_TRIG_END;
    end else begin
      it.command = CMD_UNUSED;
    end
    return it;
  endfunction

  // Leaves in_valid high after the beat is taken; the caller lowers it.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    predicted = ranging_step(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_MEASURE_PERIOD: period_ms = value;
      REG_ECHO_TIMEOUT:   timeout_ms = value;
      REG_TRIGGER_PULSE:  pulse_us = value;
      REG_TIMER_READY:    timer_ok = value[0];
      default: ;
    endcase
  endtask

  task automatic program_ranging(input logic [15:0] period, input logic [15:0] timeout,
                                 input logic [15:0] pulse, input logic ready_bit);
    write_reg(REG_MEASURE_PERIOD, period);
    write_reg(REG_ECHO_TIMEOUT, timeout);
    write_reg(REG_TRIGGER_PULSE, pulse);
    write_reg(REG_TIMER_READY, {15'($urandom_range(0, 32767)), ready_bit});
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (out_valid === 1'b1 && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("result_ready", 32'(want.result_ready), 32'(out_data.result_ready));
        compare_field("result_sensor", 32'(want.result_sensor),
                      32'(out_data.result_sensor));
        compare_field("distance_mm", 32'(want.distance_mm), 32'(out_data.distance_mm));
        compare_field("result_valid", 32'(want.result_valid), 32'(out_data.result_valid));
        compare_field("started", 32'(want.started), 32'(out_data.started));
        compare_field("started_sensor", 32'(want.started_sensor),
                      32'(out_data.started_sensor));
        compare_field("trigger_level", 32'(want.trigger_level),
                      32'(out_data.trigger_level));
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    reset_ranging();
    // First launch, an echo of the widest width, a mid-flight trigger wrap,
    // a timeout, a disable and a launch across the 32-bit millisecond wrap.
    directed_rows.push_back(stim_row(CMD_POLL, 32'd0, 1'b1, 2'd0, 16'd0, 1'b1,
                                     out_item_t'{1'b0, 2'd0, 14'd0, 1'b0, 1'b1, 2'd0, 1'b1}));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd0, 16'd0, 1'b1,
                                     out_item_t'{1'b0, 2'd0, 14'd0, 1'b0, 1'b0, 2'd0, 1'b1}));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd0, 16'hFFFF, 1'b1,
                                     out_item_t'{1'b0, 2'd0, 14'd0, 1'b0, 1'b0, 2'd0, 1'b1}));
    directed_rows.push_back(stim_row(CMD_TRIG_END, 32'd0, 1'b0, 2'd0, 16'd0, 1'b1, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd1, 1'b1, 2'd0, 16'd0, 1'b1,
                                     out_item_t'{1'b1, 2'd0, 14'd11299, 1'b1, 1'b0, 2'd0,
                                                 1'b0}));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd61, 1'b1, 2'd0, 16'd0, 1'b1,
                                     out_item_t'{1'b0, 2'd0, 14'd0, 1'b0, 1'b1, 2'd1, 1'b1}));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd0, 16'd5, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd1, 16'd5, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd1, 16'd3, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd1, 16'd7, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd62, 1'b1, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_TRIG_END, 32'd0, 1'b0, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_TRIG_END, 32'd0, 1'b0, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd121, 1'b1, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd151, 1'b1, 2'd0, 16'd0, 1'b1,
                                     out_item_t'{1'b1, 2'd2, 14'd0, 1'b0, 1'b0, 2'd0, 1'b0}));
    directed_rows.push_back(stim_row(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 2'd3, 16'hFFFF,
                                     1'b1, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd200, 1'b0, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd201, 1'b1, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'hFFFF_FFFF, 1'b1, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd3, 16'hFFFF, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_TRIG_END, 32'd0, 1'b0, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_CAPTURE, 32'd0, 1'b0, 2'd3, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd0, 1'b1, 2'd0, 16'd0, 1'b0, '0));
    directed_rows.push_back(stim_row(CMD_POLL, 32'd30, 1'b0, 2'd2, 16'hAAAA, 1'b0, '0));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      // Every boundary holds the sender back until all results are in.
      wait_drained();
      case (ph)
        1: program_ranging(16'd0, 16'd0, 16'd0, 1'b1);
        2: program_ranging(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        3: program_ranging(16'd1, 16'd1, 16'd1, 1'b1);
        4: program_ranging(16'd20, 16'd40, 16'd100, 1'b0);
        5: program_ranging(16'($urandom_range(1, 100)), 16'($urandom_range(1, 100)),
                           16'($urandom_range(1, 65535)), 1'b1);
        6: program_ranging(16'd60, 16'd30, 16'd10, 1'b1);
        7: program_ranging(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                           16'($urandom_range(0, 65535)), 1'b1);
        default: ;
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      step_hi = 32'(period_ms) / 2 + 32'(timeout_ms) / 4 + 2;
      clock_ms = ($urandom_range(0, 3) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
                                              : $urandom;
      for (int n = 0; n < ITEMS_PER_PHASE; n++)
        send_item(random_ranging_item(), 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/uer_pkg.sv
rtl/core/uer_cfg_regs.sv
rtl/core/uer_range_core.sv
rtl/core/ultrasonic_echo_ranging_scheduler.sv
tb/ultrasonic_echo_ranging_scheduler_tb.sv
